/* sv/bmis_pkg.sv */
package bmis_pkg;

	// Width of one sensor sample and of the median result.
	localparam int unsigned SAMPLE_W = 16;

	typedef logic [SAMPLE_W-1:0] sample_t;

	// Per-cell control from the top level: a beat is being taken this cycle,
	// the cell holds a live entry, and the cell is the first free slot.
	typedef struct packed {
		logic accept;
		logic occ;
		logic at_end;
	} cell_ctl_t;

endpackage

/* sv/bmis_cell.sv */
module bmis_cell (
	input  logic                 clk,
	input  bmis_pkg::cell_ctl_t  ctl,
	input  bmis_pkg::sample_t    sample,
	input  bmis_pkg::sample_t    left_value,
	input  logic                 left_gt,
	output bmis_pkg::sample_t    value,
	output logic                 gt,
	output bmis_pkg::sample_t    next_value
);

	bmis_pkg::sample_t value_q;

	// A live entry greater than the new sample must move one place right.
	assign gt = ctl.occ && (value_q > sample);

	// Take the left neighbor when it moves, else take the sample if this is
	// its slot (first greater entry or first free slot), else hold.
	always_comb begin
		if (left_gt) begin
			next_value = left_value;
		end else if (gt || ctl.at_end) begin
			next_value = sample;
		end else begin
			next_value = value_q;
		end
	end

	// Entry register; its contents are only meaningful below the fill count.
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			value_q <= next_value;
		end
	end

	assign value = value_q;

endmodule

/* sv/block_median_insertion_sorter_top.sv */
// Channel   | Direction | Handshake                    | Payload
// ----------+-----------+------------------------------+----------------
// sample    | in        | sample_valid / sample_ready  | sample [15:0]
// median    | out       | median_valid / median_ready  | median [15:0]
//
// One sample beat is taken per cycle while sample_ready is high; a row of WINDOW cells compares every
// entry with the new sample at once and shifts the larger ones right.
// Every WINDOW-th sample yields one median beat, registered when that sample is taken.
// Reset clears the fill count and the output valid; cell contents are not reset.
// sample_ready drops only while a median beat waits and median_ready is low.
module block_median_insertion_sorter_top #(
	parameter int unsigned WINDOW = 29
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bmis_pkg::sample_t   sample,
	input  logic                sample_valid,
	output logic                sample_ready,
	output bmis_pkg::sample_t   median,
	output logic                median_valid,
	input  logic                median_ready
);

	localparam int unsigned CW  = $clog2(WINDOW);
	localparam int unsigned MID = WINDOW / 2;

	logic [CW-1:0]       count_q;
	logic                median_valid_q;
	bmis_pkg::sample_t   median_q;
	logic                accept;
	logic                full;

	bmis_pkg::cell_ctl_t ctl       [WINDOW];
	bmis_pkg::sample_t   cell_val  [WINDOW];
	bmis_pkg::sample_t   cell_next [WINDOW];
	logic                cell_gt   [WINDOW];

	// Input is taken whenever the output register is free or draining.
	assign sample_ready = !median_valid_q || median_ready;
	assign accept       = sample_valid && sample_ready;
	assign full         = (count_q == CW'(WINDOW - 1));

	// Row of insertion cells, each fed by its left neighbor.
	for (genvar k = 0; k < WINDOW; k++) begin : g_cell
		assign ctl[k].accept = accept;
		assign ctl[k].occ    = (CW'(k) < count_q);
		assign ctl[k].at_end = (CW'(k) == count_q);

		if (k == 0) begin : g_first
			bmis_cell u_cell (
				.clk        (clk),
				.ctl        (ctl[k]),
				.sample     (sample),
				.left_value ('0),
				.left_gt    (1'b0),
				.value      (cell_val[k]),
				.gt         (cell_gt[k]),
				.next_value (cell_next[k])
			);
		end else begin : g_rest
			bmis_cell u_cell (
				.clk        (clk),
				.ctl        (ctl[k]),
				.sample     (sample),
				.left_value (cell_val[k-1]),
				.left_gt    (cell_gt[k-1]),
				.value      (cell_val[k]),
				.gt         (cell_gt[k]),
				.next_value (cell_next[k])
			);
		end
	end

	// Fill count: wraps to zero on the beat that completes a block.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			if (full) begin
				count_q <= '0;
			end else begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			median_valid_q <= 1'b0;
		end else if (accept && full) begin
			median_valid_q <= 1'b1;
		end else if (median_ready) begin
			median_valid_q <= 1'b0;
		end
	end

	// Capture the middle entry of the completed, sorted block.
	always_ff @(posedge clk) begin
		if (accept && full) begin
			median_q <= cell_next[MID];
		end
	end

	assign median       = median_q;
	assign median_valid = median_valid_q;

endmodule
